### rtl/xbms_pkg.sv
// xbms_pkg: shared constants and types for the GF(2) basis block.
// Used by xbms_cell and xor_basis_max_subset; depends on nothing.
`timescale 1ns / 1ps

package xbms_pkg;

   localparam int WIDTH_DEF    = 60;
   localparam int VECTOR_W     = 60;
   localparam int RANK_FIELD_W = 6;
   localparam int REQ_DATA_W   = 64;
   localparam int RSP_DATA_W   = 72;

   localparam int RSP_JOIN_BIT = VECTOR_W;
   localparam int RSP_RANK_LO  = VECTOR_W + 1;

   typedef struct packed {
      logic valid;
      logic done;
   } ins_ctl_type;

endpackage

### rtl/xor_basis_max_subset.sv
// xor_basis_max_subset: top level, a chain of WIDTH xbms_cell rows plus the response register.
// Depends on xbms_pkg and xbms_cell.
//
// Keeps a GF(2) linear basis of WIDTH-bit vectors, cleared by reset, and answers every
// request with the largest subset XOR of all vectors so far, whether this vector joined
// the basis, and the rank. The chain holds one cell per leading bit, top bit first; a
// request walks down one cell per cycle, the max-XOR sweep one cell behind it, so one
// request is taken every cycle unless the chain stalls; the response register loads as
// the sweep leaves the last cell. The chain stalls only when its last stage holds a
// response and the response register is full and not being read.
`timescale 1ns / 1ps

module xor_basis_max_subset #(
   parameter int WIDTH = xbms_pkg::WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [59:0] vector_value, [63:60] zero
   input  logic [xbms_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [59:0] max_xor, [60] joined_basis, [66:61] basis_rank, [71:67] zero
   output logic [xbms_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   localparam int RANK_W = $clog2(WIDTH + 1);
   localparam int VW     = xbms_pkg::VECTOR_W;
   localparam int RW     = xbms_pkg::RANK_FIELD_W;

   logic [WIDTH-1:0]      ins_vec  [WIDTH:0];
   xbms_pkg::ins_ctl_type ins_ctl  [WIDTH:0];
   logic                  mx_valid [WIDTH:0];
   logic [WIDTH-1:0]      mx_acc   [WIDTH:0];
   logic [RANK_W-1:0]     mx_rank  [WIDTH:0];

   logic            advance;
   logic            joined_dly_ff;
   logic            out_valid_ff, out_valid_in;
   logic [VW-1:0]   out_max_ff;
   logic            out_join_ff;
   logic [RW-1:0]   out_rank_ff;
   logic [VW-1:0]   max_field;
   logic [RW-1:0]   rank_field;
   logic            load_out;

   assign advance    = !mx_valid[0] || !out_valid_ff || rsp_tready;
   assign req_tready = advance;
   assign load_out   = advance && mx_valid[0];

   generate
      if (WIDTH > VW) begin : g_in_wide
         assign ins_vec[WIDTH] = {{(WIDTH - VW){1'b0}}, req_tdata[VW-1:0]};
         assign max_field      = mx_acc[0][VW-1:0];
      end else if (WIDTH == VW) begin : g_in_equal
         assign ins_vec[WIDTH] = req_tdata[VW-1:0];
         assign max_field      = mx_acc[0];
      end else begin : g_in_narrow
         assign ins_vec[WIDTH] = req_tdata[WIDTH-1:0];
         assign max_field      = {{(VW - WIDTH){1'b0}}, mx_acc[0]};
      end
      if (RANK_W >= RW) begin : g_rank_wide
         assign rank_field = mx_rank[0][RW-1:0];
      end else begin : g_rank_narrow
         assign rank_field = {{(RW - RANK_W){1'b0}}, mx_rank[0]};
      end
   endgenerate

   assign ins_ctl[WIDTH].valid = req_tvalid && req_tready;
   assign ins_ctl[WIDTH].done  = 1'b0;
   assign mx_valid[WIDTH]      = ins_ctl[WIDTH-1].valid;
   assign mx_acc[WIDTH]        = '0;
   assign mx_rank[WIDTH]       = '0;

   genvar gi;
   generate
      for (gi = WIDTH - 1; gi >= 0; gi--) begin : g_cell
         xbms_cell #(
            .WIDTH  (WIDTH),
            .BIT    (gi),
            .RANK_W (RANK_W)
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .en         (advance),
            .ins_vec_i  (ins_vec[gi+1]),
            .ins_ctl_i  (ins_ctl[gi+1]),
            .ins_vec_o  (ins_vec[gi]),
            .ins_ctl_o  (ins_ctl[gi]),
            .mx_valid_i (mx_valid[gi+1]),
            .mx_acc_i   (mx_acc[gi+1]),
            .mx_rank_i  (mx_rank[gi+1]),
            .mx_valid_o (mx_valid[gi]),
            .mx_acc_o   (mx_acc[gi]),
            .mx_rank_o  (mx_rank[gi])
         );
      end
   endgenerate

   always_comb begin
      if (load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         joined_dly_ff <= ins_ctl[0].done;
      end
      if (load_out) begin
         out_max_ff  <= max_field;
         out_join_ff <= joined_dly_ff;
         out_rank_ff <= rank_field;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(xbms_pkg::RSP_DATA_W - VW - 1 - RW){1'b0}},
                        out_rank_ff, out_join_ff, out_max_ff};

endmodule

### rtl/xbms_cell.sv
// xbms_cell: one basis row of the chain, the owner of leading bit BIT.
// Reduces the insert wave, then folds its row into the max-XOR wave that trails it.
// Depends on xbms_pkg.
`timescale 1ns / 1ps

module xbms_cell #(
   parameter int WIDTH  = xbms_pkg::WIDTH_DEF,
   parameter int BIT    = 0,
   parameter int RANK_W = $clog2(WIDTH + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic [WIDTH-1:0]      ins_vec_i,
   input  xbms_pkg::ins_ctl_type ins_ctl_i,
   output logic [WIDTH-1:0]      ins_vec_o,
   output xbms_pkg::ins_ctl_type ins_ctl_o,
   input  logic                  mx_valid_i,
   input  logic [WIDTH-1:0]      mx_acc_i,
   input  logic [RANK_W-1:0]     mx_rank_i,
   output logic                  mx_valid_o,
   output logic [WIDTH-1:0]      mx_acc_o,
   output logic [RANK_W-1:0]     mx_rank_o
);

   logic [WIDTH-1:0]      row_ff, row_in;
   logic [WIDTH-1:0]      ins_vec_ff, ins_vec_in;
   xbms_pkg::ins_ctl_type ins_ctl_ff, ins_ctl_in;
   logic                  mx_valid_ff, mx_valid_in;
   logic [WIDTH-1:0]      mx_acc_ff, mx_acc_in;
   logic [RANK_W-1:0]     mx_rank_ff, mx_rank_in;

   logic hit, store, row_nz;

   always_comb begin
      hit    = ins_ctl_i.valid && !ins_ctl_i.done && ins_vec_i[BIT];
      store  = hit && (row_ff == '0);
      row_nz = (row_ff != '0);

      row_in           = store ? ins_vec_i : row_ff;
      ins_vec_in       = (hit && !store) ? (ins_vec_i ^ row_ff) : ins_vec_i;
      ins_ctl_in.valid = ins_ctl_i.valid;
      ins_ctl_in.done  = ins_ctl_i.done | store;

      mx_valid_in = mx_valid_i;
      mx_acc_in   = (mx_valid_i && row_nz && !mx_acc_i[BIT]) ? (mx_acc_i ^ row_ff) : mx_acc_i;
      mx_rank_in  = (mx_valid_i && row_nz) ? (mx_rank_i + RANK_W'(1)) : mx_rank_i;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff         <= '0;
         ins_ctl_ff     <= '0;
         mx_valid_ff    <= 1'b0;
      end else if (en) begin
         row_ff         <= row_in;
         ins_ctl_ff     <= ins_ctl_in;
         mx_valid_ff    <= mx_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ins_vec_ff <= ins_vec_in;
         mx_acc_ff  <= mx_acc_in;
         mx_rank_ff <= mx_rank_in;
      end
   end

   assign ins_vec_o  = ins_vec_ff;
   assign ins_ctl_o  = ins_ctl_ff;
   assign mx_valid_o = mx_valid_ff;
   assign mx_acc_o   = mx_acc_ff;
   assign mx_rank_o  = mx_rank_ff;

endmodule
